/* hdl/gbs_pkg.sv */
// Shared types, constants and blur arithmetic for the blur-and-sharpen filter.
package gbs_pkg;

    // Line geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int REG_W     = 12;
    localparam int WUSE_W    = (REG_W > $clog2(MAX_WIDTH + 1)) ? REG_W : $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = REG_W + 1;
    localparam int MIN_DIM   = 7;

    // Pixel and line words
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int LINE_ROWS = 6;
    localparam int LINE_W    = LINE_ROWS * PIX_W;
    localparam int BL_W      = 2 * PIX_W;

    // Output queue
    localparam int OUT_DEPTH = 8;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [REG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [REG_W-1:0] RESET_HEIGHT = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Control for one pipeline step
    typedef struct packed {
        logic             valid;
        logic             item_end;
        logic             line_wr;
        logic             vert_en;
        logic             horz_en;
        logic             sharp_en;
        logic             emit;
        logic             last;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] bcol;
    } step_t;

    typedef struct packed {
        logic last;
        pix_t pix;
    } res_t;

    // 7-tap binomial blur of one channel, divided by 64
    function automatic logic [CH_W-1:0] blur_ch(input logic [CH_W-1:0] a0, a1, a2, a3,
                                                input logic [CH_W-1:0] a4, a5, a6);
        logic [13:0] e0, e1, e2, mid, sum;
        e0  = 14'(a0) + 14'(a6);
        e1  = 14'(a1) + 14'(a5);
        e2  = 14'(a2) + 14'(a4);
        mid = 14'(a3);
        sum = e0 + (e1 << 2) + (e1 << 1) + (e2 << 4) - e2 + (mid << 4) + (mid << 2);
        return sum[13:6];
    endfunction

    // Blur all three channels; p0 is the oldest tap
    function automatic pix_t blur_pix(input pix_t p0, p1, p2, p3, p4, p5, p6);
        pix_t r;
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            r[CH_W*k +: CH_W] = blur_ch(p0[CH_W*k +: CH_W], p1[CH_W*k +: CH_W],
                                        p2[CH_W*k +: CH_W], p3[CH_W*k +: CH_W],
                                        p4[CH_W*k +: CH_W], p5[CH_W*k +: CH_W],
                                        p6[CH_W*k +: CH_W]);
        end
        return r;
    endfunction

endpackage

/* hdl/gbs_vblur.sv */
// Input line memory and vertical 7-tap blur stage.
module gbs_vblur (
    input  logic           clk,
    input  logic           rst_n,
    input  gbs_pkg::step_t s0_step,
    input  gbs_pkg::pix_t  s0_pix,
    output gbs_pkg::step_t s2_step,
    output gbs_pkg::pix_t  s2_vert
);
    import gbs_pkg::*;

    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_reg;
    step_t             s1_step_reg;
    pix_t              s1_pix_reg;
    step_t             s2_step_reg;
    pix_t              vert_reg;
    pix_t              vert_next;

    // Read the six-row column word for the issued step
    always_ff @(posedge clk)
    begin
        rd_reg <= line_mem[s0_step.col];
        if (s1_step_reg.valid && s1_step_reg.line_wr)
        begin
            line_mem[s1_step_reg.col] <= {s1_pix_reg, rd_reg[LINE_W-1:PIX_W]};
        end
    end

    // Vertical blur over six stored rows and the new pixel
    always_comb
    begin
        vert_next = '0;
        if (s1_step_reg.vert_en)
        begin
            vert_next = blur_pix(rd_reg[0*PIX_W +: PIX_W], rd_reg[1*PIX_W +: PIX_W],
                                 rd_reg[2*PIX_W +: PIX_W], rd_reg[3*PIX_W +: PIX_W],
                                 rd_reg[4*PIX_W +: PIX_W], rd_reg[5*PIX_W +: PIX_W],
                                 s1_pix_reg);
        end
    end

    // Advance the stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_step_reg <= '0;
            s2_step_reg <= '0;
        end
        else
        begin
            s1_step_reg <= s0_step;
            s2_step_reg <= s1_step_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg <= s0_pix;
        vert_reg   <= vert_next;
    end

    assign s2_step = s2_step_reg;
    assign s2_vert = vert_reg;

endmodule

/* hdl/gbs_hsharp.sv */
// Horizontal blur taps, blurred line memory and 3x3 sharpen stage.
module gbs_hsharp (
    input  logic           clk,
    input  logic           rst_n,
    input  gbs_pkg::step_t s0_step,
    input  gbs_pkg::step_t s2_step,
    input  gbs_pkg::pix_t  s2_vert,
    output logic           push,
    output gbs_pkg::res_t  push_data,
    output logic           release_credit
);
    import gbs_pkg::*;

    logic [BL_W-1:0] bl_mem [MAX_WIDTH];
    logic [BL_W-1:0] rd_reg;
    logic [BL_W-1:0] nb_reg;
    pix_t            taps_reg [LINE_ROWS];
    pix_t            win_reg  [6];
    pix_t            n0;
    pix_t            n1;
    pix_t            hblur;
    pix_t            sharp;

    function automatic logic [CH_W-1:0] sharpen_ch(input logic [CH_W-1:0] ctr, up, dn,
                                                   input logic [CH_W-1:0] lf, rt);
        logic signed [11:0] s;
        logic [CH_W-1:0]    r;
        s = 12'sd5 * $signed({4'b0, ctr}) - $signed({4'b0, up}) - $signed({4'b0, dn})
            - $signed({4'b0, lf}) - $signed({4'b0, rt});
        if (s < 12'sd0)
        begin
            r = '0;
        end
        else if (s > 12'sd255)
        begin
            r = '1;
        end
        else
        begin
            r = s[CH_W-1:0];
        end
        return r;
    endfunction

    // Read the two stored blurred rows; align them with the blur stage
    always_ff @(posedge clk)
    begin
        rd_reg <= bl_mem[s0_step.bcol];
        nb_reg <= rd_reg;
        if (s2_step.valid && s2_step.sharp_en)
        begin
            bl_mem[s2_step.bcol] <= {hblur, n1};
        end
    end

    assign n0 = nb_reg[PIX_W-1:0];
    assign n1 = nb_reg[BL_W-1:PIX_W];

    // Horizontal blur and sharpen of the previous window column
    always_comb
    begin
        hblur = '0;
        if (s2_step.horz_en)
        begin
            hblur = blur_pix(taps_reg[0], taps_reg[1], taps_reg[2], taps_reg[3],
                             taps_reg[4], taps_reg[5], s2_vert);
        end
        sharp = '0;
        for (int k = 0; k < 3; k++)
        begin
            sharp[CH_W*k +: CH_W] = sharpen_ch(win_reg[4][CH_W*k +: CH_W],
                                               win_reg[3][CH_W*k +: CH_W],
                                               win_reg[5][CH_W*k +: CH_W],
                                               win_reg[1][CH_W*k +: CH_W],
                                               n1[CH_W*k +: CH_W]);
        end
    end

    // Shift taps every step and the window on every sharpen step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_ROWS; i++)
            begin
                taps_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s2_step.valid)
        begin
            for (int i = 0; i < LINE_ROWS - 1; i++)
            begin
                taps_reg[i] <= taps_reg[i+1];
            end
            taps_reg[LINE_ROWS-1] <= s2_vert;
            if (s2_step.sharp_en)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= n0;
                win_reg[4] <= n1;
                win_reg[5] <= hblur;
            end
        end
    end

    assign push           = s2_step.valid && s2_step.emit;
    assign push_data.last = s2_step.last;
    assign push_data.pix  = sharp;
    assign release_credit = s2_step.valid && s2_step.item_end && !s2_step.emit;

endmodule

/* hdl/gbs_out_fifo.sv */
// Output queue of finished items.
module gbs_out_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbs_pkg::res_t push_data,
    output logic          out_valid,
    input  logic          out_stall,
    output gbs_pkg::res_t head,
    output logic          pop
);
    import gbs_pkg::*;

    res_t             q_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = q_reg[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(OUT_DEPTH)))
        else $error("output queue overflow");

endmodule

/* hdl/gauss7_blur_sharpen3x3_filter.sv */
// Top level: step sequencer, frame position tracking and filter pipeline.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  input     | in_valid/in_stall  | op, pixel_red, pixel_green, pixel_blue
//  output    | out_valid/out_stall| out_red, out_green, out_blue, frame_last
//  config    | cfg_wr_en          | cfg_index, cfg_data
//
//  A pixel in the frame is one pipeline step; a new item is taken every cycle
//  unless in_stall is high. An item past the frame runs one to four steps,
//  one per cycle, stalling the input meanwhile; a flush inside the frame
//  runs none. A result passes the s1 and s2 stage registers, then the queue.
//  Input stalls when eight items are in flight or queued for output.
//  Reset (rst_n, async) restores 640x480 and the start of a frame.
module gauss7_blur_sharpen3x3_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [7:0]                    pixel_red,
    input  logic [7:0]                    pixel_green,
    input  logic [7:0]                    pixel_blue,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    out_red,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic                          frame_last,
    input  logic                          cfg_wr_en,
    input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbs_pkg::REG_W-1:0]     cfg_data
);
    import gbs_pkg::*;

    logic [WUSE_W-1:0] w_used_reg;
    logic [REG_W-1:0]  h_used_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [REG_W-1:0]  orow_reg;
    logic [COL_W-1:0]  ocol_reg;
    logic              busy_reg;
    logic [1:0]        dcnt_reg;
    logic [CNT_W-1:0]  credit_reg;

    logic              in_frame;
    logic              in_step;
    logic              step_go;
    logic              c_ge3;
    logic              sharp_en;
    logic [ROW_W-1:0]  srow;
    logic [WUSE_W-1:0] wrap_sum;
    logic [COL_W-1:0]  scol;
    logic              emit;
    logic              last;
    logic              item_end;
    logic              col_end;
    logic              ocol_end;
    step_t             s0_step;
    pix_t              s0_pix;
    step_t             s2_step;
    pix_t              s2_vert;
    logic              push;
    res_t              push_data;
    logic              rel;
    res_t              head;
    logic              pop;

    // Issue a step for pixels in the frame and for ticks past its end
    assign in_frame = row_reg < ROW_W'(h_used_reg);
    assign in_stall = busy_reg || (credit_reg == CNT_W'(OUT_DEPTH));
    assign in_step  = in_valid && !in_stall && (!in_frame || op == OP_PIXEL);
    assign step_go  = busy_reg || in_step;

    // Map the step position onto the sharpen grid
    always_comb
    begin
        c_ge3    = col_reg >= COL_W'(3);
        sharp_en = c_ge3 ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(4));
        srow     = c_ge3 ? (row_reg - ROW_W'(3)) : (row_reg - ROW_W'(4));
        wrap_sum = w_used_reg - WUSE_W'(3) + WUSE_W'(col_reg);
        scol     = c_ge3 ? (col_reg - COL_W'(3)) : wrap_sum[COL_W-1:0];
        emit     = sharp_en && (srow != '0) && (scol != '0)
                   && (srow - ROW_W'(1) == ROW_W'(orow_reg))
                   && (scol - COL_W'(1) == ocol_reg);
        ocol_end = WUSE_W'(ocol_reg) == w_used_reg - WUSE_W'(2);
        last     = (orow_reg == h_used_reg - REG_W'(2)) && ocol_end;
        col_end  = WUSE_W'(col_reg) == w_used_reg - WUSE_W'(1);
        item_end = in_frame || emit || (dcnt_reg == 2'd3);
    end

    always_comb
    begin
        s0_step.valid    = step_go;
        s0_step.item_end = item_end;
        s0_step.line_wr  = in_frame;
        s0_step.vert_en  = in_frame && (row_reg >= ROW_W'(LINE_ROWS));
        s0_step.horz_en  = col_reg >= COL_W'(LINE_ROWS);
        s0_step.sharp_en = sharp_en;
        s0_step.emit     = emit;
        s0_step.last     = last;
        s0_step.col      = col_reg;
        s0_step.bcol     = scol;
        s0_pix           = in_frame ? {pixel_blue, pixel_green, pixel_red} : '0;
    end

    // Hold configuration and advance frame positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_used_reg <= WUSE_W'(RESET_WIDTH);
            h_used_reg <= RESET_HEIGHT;
            row_reg    <= '0;
            col_reg    <= '0;
            orow_reg   <= REG_W'(1);
            ocol_reg   <= COL_W'(1);
            busy_reg   <= 1'b0;
            dcnt_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:
                begin
                    if (cfg_data < REG_W'(MIN_DIM))
                    begin
                        w_used_reg <= WUSE_W'(MIN_DIM);
                    end
                    else if (WUSE_W'(cfg_data) > WUSE_W'(MAX_WIDTH))
                    begin
                        w_used_reg <= WUSE_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        w_used_reg <= WUSE_W'(cfg_data);
                    end
                end
                REG_FRAME_HEIGHT:
                begin
                    h_used_reg <= (cfg_data < REG_W'(MIN_DIM)) ? REG_W'(MIN_DIM) : cfg_data;
                end
                default:
                begin
                    h_used_reg <= h_used_reg;
                end
            endcase
            row_reg  <= '0;
            col_reg  <= '0;
            orow_reg <= REG_W'(1);
            ocol_reg <= COL_W'(1);
            busy_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (step_go)
        begin
            if (emit && last)
            begin
                row_reg  <= '0;
                col_reg  <= '0;
                orow_reg <= REG_W'(1);
                ocol_reg <= COL_W'(1);
            end
            else
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
                if (emit)
                begin
                    if (ocol_end)
                    begin
                        ocol_reg <= COL_W'(1);
                        orow_reg <= orow_reg + REG_W'(1);
                    end
                    else
                    begin
                        ocol_reg <= ocol_reg + COL_W'(1);
                    end
                end
            end
            if (!item_end)
            begin
                busy_reg <= 1'b1;
                dcnt_reg <= dcnt_reg + 2'd1;
            end
            else
            begin
                busy_reg <= 1'b0;
                dcnt_reg <= '0;
            end
        end
    end

    // Count items accepted whose result slot is still held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_reg + CNT_W'(in_step) - CNT_W'(pop) - CNT_W'(rel);
        end
    end

    gbs_vblur u_vblur (
        .clk     (clk),
        .rst_n   (rst_n),
        .s0_step (s0_step),
        .s0_pix  (s0_pix),
        .s2_step (s2_step),
        .s2_vert (s2_vert)
    );

    gbs_hsharp u_hsharp (
        .clk            (clk),
        .rst_n          (rst_n),
        .s0_step        (s0_step),
        .s2_step        (s2_step),
        .s2_vert        (s2_vert),
        .push           (push),
        .push_data      (push_data),
        .release_credit (rel)
    );

    gbs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .pop       (pop)
    );

    assign out_red    = head.pix[0*CH_W +: CH_W];
    assign out_green  = head.pix[1*CH_W +: CH_W];
    assign out_blue   = head.pix[2*CH_W +: CH_W];
    assign frame_last = head.last;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CNT_W'(OUT_DEPTH))
        else $error("credit count above queue depth");

    a_busy_drain: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (!in_frame && dcnt_reg != 2'd0))
        else $error("flush sequencing inside the frame");

    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_reg != '0))
        else $error("result present without a held credit");

endmodule
